// ----- rtl/ka_pkg.sv -----
// ============================================================================
// ka_pkg
// Shared types and constants of the keepalive supervisor: operation and
// event codes, field widths, controller states and the command and status
// bundles between the controller and the datapath.
// ============================================================================
package ka_pkg;

   localparam int unsigned MIN_INTERVAL_MS_DEF = 100;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned IVL_W    = 24;
   localparam int unsigned PERIOD_W = 22;
   localparam int unsigned LIM_W    = 20;
   localparam int unsigned EV_W     = 2;

   // Divider operand widths: numerators reach 2^24 + 2^22 - 3, divisors 2^23 - 2.
   localparam int unsigned NUM_W = IVL_W + 1;
   localparam int unsigned DEN_W = PERIOD_W + 1;

   localparam logic [OP_W-1:0] OP_MS_TICK = 3'd0;
   localparam logic [OP_W-1:0] OP_RX      = 3'd1;
   localparam logic [OP_W-1:0] OP_TX      = 3'd2;
   localparam logic [OP_W-1:0] OP_PEER    = 3'd3;
   localparam logic [OP_W-1:0] OP_START   = 3'd4;

   localparam logic [EV_W-1:0] EV_NONE      = 2'd0;
   localparam logic [EV_W-1:0] EV_KEEPALIVE = 2'd1;
   localparam logic [EV_W-1:0] EV_TIMEOUT   = 2'd2;
   localparam logic [EV_W-1:0] EV_CLOSED    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_PREP,
      ST_LIN_GO,
      ST_LIN_WAIT,
      ST_LOUT_GO,
      ST_LOUT_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic latch;      // capture the accepted request
      logic apply;      // execute an operation that needs no recompute and load the result
      logic prep;       // clamp intervals and select the tick period
      logic div_go;     // start the shared divider
      logic div_sel;    // 0: inbound limit, 1: outbound limit
      logic store_lin;  // take the quotient as inbound limit
      logic store_lout; // take the quotient as outbound limit
      logic finish;     // commit the new period and load the result
   } ka_cmd_type;

   typedef struct packed {
      logic needs_calc; // request requires a timer recompute
      logic has_any;    // at least one interval is enabled
      logic slot_free;  // result register can take a new result
      logic div_done;   // divider quotient is ready
   } ka_stat_type;

endpackage

// ----- rtl/ka_div.sv -----
// ============================================================================
// ka_div
// Restoring radix-2 divider, one quotient bit per cycle. The quotient is
// valid in the cycle that done is high.
// ============================================================================
module ka_div
   import ka_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int unsigned CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The dividend shifts out of the top as quotient bits shift in.
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- rtl/ka_dpath.sv -----
// ============================================================================
// ka_dpath
// Datapath of the keepalive supervisor: request and interval registers,
// timer state, limit computation through the shared divider, and the
// result register.
// ============================================================================
module ka_dpath
   import ka_pkg::*;
#(
   parameter int unsigned MIN_INTERVAL_MS = MIN_INTERVAL_MS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [IVL_W-1:0]    req_peer_interval,
   input  logic                req_pipe_open,
   input  logic                csr_wr_en,
   input  logic [IVL_W-1:0]    csr_wr_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [EV_W-1:0]     rsp_event_code,
   output logic [PERIOD_W-1:0] rsp_period_ms,
   input  ka_cmd_type          cmd,
   output ka_stat_type         stat
);

   localparam logic [IVL_W-1:0] MIN_IVL = IVL_W'(MIN_INTERVAL_MS);
   localparam logic [LIM_W-1:0] CNT_MAX = '1;

   function automatic logic [IVL_W-1:0] clamp_ivl(input logic [IVL_W-1:0] v);
      logic [IVL_W-1:0] r;
      r = v;
      if (v != '0 && v < MIN_IVL) begin
         r = MIN_IVL;
      end
      return r;
   endfunction

   logic [IVL_W-1:0]    local_ivl_ff, local_ivl_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [IVL_W-1:0]    peer_ff, peer_in;
   logic                pipe_ff, pipe_in;
   logic [IVL_W-1:0]    peer_ivl_ff, peer_ivl_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] countdown_ff, countdown_in;
   logic [LIM_W-1:0]    lim_in_ff, lim_in_in;
   logic [LIM_W-1:0]    lim_out_ff, lim_out_in;
   logic [LIM_W-1:0]    cnt_in_ff, cnt_in_in;
   logic [LIM_W-1:0]    cnt_out_ff, cnt_out_in;
   logic                running_ff, running_in;
   logic [IVL_W-1:0]    loc_ff, loc_in;
   logic [PERIOD_W-1:0] t_ff, t_in;
   logic                has_any_ff, has_any_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [EV_W-1:0]     rsp_event_ff, rsp_event_in;
   logic [PERIOD_W-1:0] rsp_period_ff, rsp_period_in;

   logic [IVL_W-1:0]    loc_c, peer_c;
   logic [PERIOD_W-1:0] tin_c, tout_c, tsel_c, t_c;
   logic [LIM_W-1:0]    cin_inc, cout_inc;
   logic                slot_free;
   logic [PERIOD_W-1:0] new_period;
   logic [EV_W-1:0]     ev;
   logic                load_out;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic                div_done;
   logic [NUM_W-1:0]    div_quo;

   // Tick period: the smaller nonzero quarter of the clamped intervals, or 1 if both are zero.
   assign loc_c  = clamp_ivl(local_ivl_ff);
   assign peer_c = clamp_ivl(peer_ff);
   assign tin_c  = loc_c[IVL_W-1:2];
   assign tout_c = peer_c[IVL_W-1:2];
   assign tsel_c = (tin_c == '0) ? tout_c :
                   ((tout_c == '0 || tout_c > tin_c) ? tin_c : tout_c);
   assign t_c    = (tsel_c == '0) ? PERIOD_W'(1) : tsel_c;

   assign cin_inc  = (cnt_in_ff == CNT_MAX) ? cnt_in_ff : cnt_in_ff + 1'b1;
   assign cout_inc = (cnt_out_ff == CNT_MAX) ? cnt_out_ff : cnt_out_ff + 1'b1;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign new_period = has_any_ff ? t_ff : '0;

   // Inbound limit rounds up; outbound limit is (peer + 1) / (2 * period).
   always_comb begin
      if (cmd.div_sel) begin
         div_num = NUM_W'({1'b0, peer_ivl_ff} + 1'b1);
         div_den = {t_ff, 1'b0};
      end else begin
         div_num = NUM_W'({1'b0, loc_ff} + NUM_W'(t_ff) - 1'b1);
         div_den = {1'b0, t_ff};
      end
   end

   ka_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      local_ivl_in  = local_ivl_ff;
      op_in         = op_ff;
      peer_in       = peer_ff;
      pipe_in       = pipe_ff;
      peer_ivl_in   = peer_ivl_ff;
      period_in     = period_ff;
      countdown_in  = countdown_ff;
      lim_in_in     = lim_in_ff;
      lim_out_in    = lim_out_ff;
      cnt_in_in     = cnt_in_ff;
      cnt_out_in    = cnt_out_ff;
      running_in    = running_ff;
      loc_in        = loc_ff;
      t_in          = t_ff;
      has_any_in    = has_any_ff;
      ev            = EV_NONE;
      load_out      = 1'b0;

      if (csr_wr_en) begin
         local_ivl_in = csr_wr_data;
      end

      if (cmd.latch) begin
         op_in   = req_operation;
         peer_in = req_peer_interval;
         pipe_in = req_pipe_open;
      end

      if (cmd.apply) begin
         load_out = 1'b1;
         unique case (op_ff)
            OP_MS_TICK: begin
               if (running_ff) begin
                  if (countdown_ff <= PERIOD_W'(1)) begin
                     countdown_in = period_ff;
                     if (lim_in_ff != '0) begin
                        cnt_in_in = cin_inc;
                     end
                     if (lim_in_ff != '0 && cin_inc > lim_in_ff) begin
                        running_in = 1'b0;
                        ev         = EV_TIMEOUT;
                     end else if (!pipe_ff) begin
                        running_in = 1'b0;
                        ev         = EV_CLOSED;
                     end else if (lim_out_ff != '0) begin
                        cnt_out_in = cout_inc;
                        if (cout_inc > lim_out_ff) begin
                           ev = EV_KEEPALIVE;
                        end
                     end
                  end else begin
                     countdown_in = countdown_ff - 1'b1;
                  end
               end
            end
            OP_RX: begin
               cnt_in_in = '0;
            end
            OP_TX: begin
               cnt_out_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.prep) begin
         peer_ivl_in = peer_c;
         loc_in      = loc_c;
         t_in        = t_c;
         has_any_in  = (loc_c != '0) || (peer_c != '0);
         // A start always begins from a stopped timer.
         if (op_ff == OP_START) begin
            running_in   = 1'b0;
            period_in    = '0;
            countdown_in = '0;
         end
      end

      if (cmd.store_lin) begin
         lim_in_in = div_quo[LIM_W-1:0];
      end

      if (cmd.store_lout) begin
         lim_out_in = div_quo[LIM_W-1:0];
      end

      if (cmd.finish) begin
         load_out  = 1'b1;
         period_in = new_period;
         if (has_any_ff) begin
            cnt_in_in  = '0;
            cnt_out_in = '0;
         end
         // The countdown restarts only when the period or run state changes.
         if (period_ff != new_period || running_ff != (new_period != '0)) begin
            running_in   = (new_period != '0);
            countdown_in = new_period;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_period_in = rsp_period_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_event_in  = ev;
         rsp_period_in = running_in ? period_in : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      peer_ff       <= peer_in;
      pipe_ff       <= pipe_in;
      loc_ff        <= loc_in;
      t_ff          <= t_in;
      has_any_ff    <= has_any_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_period_ff <= rsp_period_in;
      if (reset) begin
         local_ivl_ff <= '0;
         peer_ivl_ff  <= '0;
         period_ff    <= '0;
         countdown_ff <= '0;
         lim_in_ff    <= '0;
         lim_out_ff   <= '0;
         cnt_in_ff    <= '0;
         cnt_out_ff   <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         local_ivl_ff <= local_ivl_in;
         peer_ivl_ff  <= peer_ivl_in;
         period_ff    <= period_in;
         countdown_ff <= countdown_in;
         lim_in_ff    <= lim_in_in;
         lim_out_ff   <= lim_out_in;
         cnt_in_ff    <= cnt_in_in;
         cnt_out_ff   <= cnt_out_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.needs_calc = (op_ff == OP_START) ||
                            (op_ff == OP_PEER && peer_ff != peer_ivl_ff);
   assign stat.has_any    = has_any_ff;
   assign stat.slot_free  = slot_free;
   assign stat.div_done   = div_done;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;
   assign rsp_period_ms  = rsp_period_ff;

   a_run_has_period: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (period_ff != '0 && countdown_ff <= period_ff))
      else $error("timer running without a valid period and countdown");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      load_out |-> slot_free)
      else $error("result loaded while the previous one is still stalled");

endmodule

// ----- rtl/ka_ctrl.sv -----
// ============================================================================
// ka_ctrl
// Controller of the keepalive supervisor: accepts requests and sequences
// direct operations and the timer recompute with up to two divisions.
// ============================================================================
module ka_ctrl
   import ka_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ka_stat_type stat,
   output ka_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (stat.needs_calc) begin
               state_in = ST_PREP;
            end else if (stat.slot_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_LIN_GO;
         end
         ST_LIN_GO: begin
            // With both intervals disabled the limits are left as they are.
            if (stat.has_any) begin
               cmd.div_go = 1'b1;
               state_in   = ST_LIN_WAIT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LIN_WAIT: begin
            if (stat.div_done) begin
               cmd.store_lin = 1'b1;
               state_in      = ST_LOUT_GO;
            end
         end
         ST_LOUT_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = 1'b1;
            state_in    = ST_LOUT_WAIT;
         end
         ST_LOUT_WAIT: begin
            cmd.div_sel = 1'b1;
            if (stat.div_done) begin
               cmd.store_lout = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == ST_LIN_WAIT || state_ff == ST_LOUT_WAIT))
      else $error("divider finished outside a wait state");

   a_latch_goes_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> (state_ff == ST_APPLY && req_stall))
      else $error("accepted request not followed by its execution");

endmodule

// ----- rtl/keepalive_supervisor.sv -----
// ============================================================================
// keepalive_supervisor
// Connection keepalive supervisor: a millisecond countdown drives period
// ticks that check inbound silence and schedule outbound keepalives.
// ============================================================================
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, peer_interval, pipe_open
//   rsp      out        rsp_valid/rsp_stall  event_code, period_ms
//   csr      in         csr_wr_en            csr_wr_data (local interval, ms)
//
// Millisecond ticks, activity, unchanged peer updates and unused codes run
// in the apply state and load the result once the result register is free.
// A start or a changed peer interval recomputes the timer through the prep,
// divide and finish states with two passes of the shared 25-step serial
// divider, or none when both intervals are off, then loads its result.
// Reset is synchronous and clears all timer state; no clearing pass.
// A stalled result holds; one further request is accepted meanwhile and
// waits in the controller until the result register frees.
module keepalive_supervisor
   import ka_pkg::*;
#(
   parameter int unsigned MIN_INTERVAL_MS = MIN_INTERVAL_MS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [IVL_W-1:0]    req_peer_interval,
   input  logic                req_pipe_open,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [EV_W-1:0]     rsp_event_code,
   output logic [PERIOD_W-1:0] rsp_period_ms,
   input  logic                csr_wr_en,
   input  logic [IVL_W-1:0]    csr_wr_data
);

   ka_cmd_type  cmd;
   ka_stat_type stat;

   ka_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ka_dpath #(
      .MIN_INTERVAL_MS (MIN_INTERVAL_MS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_peer_interval (req_peer_interval),
      .req_pipe_open     (req_pipe_open),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_event_code    (rsp_event_code),
      .rsp_period_ms     (rsp_period_ms),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule
